// ----- rtl/core/fvspm_pkg.sv -----
// shared types, widths and helpers for the four-voice sample playback mixer
// no dependencies; compiled first
package fvspm_pkg;

    localparam int VOICES_DEF    = 4;
    localparam int MEM_DEPTH_DEF = 131072;

    localparam int DVD_W    = 32;   // divider dividend / quotient width
    localparam int LEN_W    = 17;   // lengths, offsets and byte addresses
    localparam int STEP_W   = 32;   // 16.16 step
    localparam int FRAC_W   = 16;   // fractional part of the position
    localparam int POS_W    = 48;   // 32.16 position
    localparam int VOL_W    = 7;
    localparam int SAMPLE_W = 8;
    localparam int PCM_W    = 16;
    localparam int PLAY_W   = 4;

    localparam logic [VOL_W-1:0] VOL_MAX = 7'd64;
    localparam int PCM_MAX = 32767;
    localparam int PCM_MIN = -32768;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_VOLUME = 2'd2,
        ACT_RENDER = 2'd3
    } t_action;

    typedef struct packed {
        t_action                     action;
        logic [1:0]                  voice;
        logic [LEN_W-1:0]            address;
        logic signed [SAMPLE_W-1:0]  sample_byte;
        logic [LEN_W-1:0]            sample_length;
        logic [LEN_W-1:0]            loop_begin;
        logic [LEN_W-1:0]            loop_length;
        logic [STEP_W-1:0]           step;
        logic [VOL_W-1:0]            volume;
        logic [LEN_W-1:0]            start_position;
    } t_item;

    typedef struct packed {
        logic signed [PCM_W-1:0] pcm_sample;
        logic [PLAY_W-1:0]       voices_playing;
    } t_result;

    function automatic logic [VOL_W-1:0] clamp_volume(input logic [VOL_W-1:0] vol);
        return (vol > VOL_MAX) ? VOL_MAX : vol;
    endfunction

endpackage

// ----- rtl/core/fvspm_chan_if.sv -----
// valid/ready channel carrying one payload of type T per transfer
// payload types come from fvspm_pkg
interface fvspm_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/fvspm_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on fvspm_pkg for the dividend width
module fvspm_div
    import fvspm_pkg::*;
#(
    parameter int DIV_W = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient,
    output logic [DIV_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dsr;

    logic [DIV_W:0]   trial;
    logic             fits;
    logic [DIV_W-1:0] n_rem;

    // shift in the next dividend bit and try the subtraction
    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign fits  = (trial >= {1'b0, r_dsr});
    assign n_rem = fits ? DIV_W'(trial - {1'b0, r_dsr}) : trial[DIV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DVD_W-2:0], fits};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- rtl/core/fvspm_mac.sv -----
// voice multiply-accumulate: byte times volume, registered, then summed times four
// depends on fvspm_pkg for sample and volume widths
module fvspm_mac
    import fvspm_pkg::*;
#(
    parameter int ACC_W = 19
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clr,
    input  logic                       i_add,
    input  logic signed [SAMPLE_W-1:0] i_byte,
    input  logic [VOL_W-1:0]           i_vol,
    output logic signed [ACC_W-1:0]    o_acc
);

    localparam int PROD_W = SAMPLE_W + VOL_W + 1;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_x4;

    assign prod_x4 = ACC_W'(r_prod) <<< 2;

    always_ff @(posedge i_clk) begin
        r_prod <= i_byte * $signed({1'b0, i_vol});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else if (i_clr) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= i_add;
            if (r_prod_vld) begin
                r_acc <= r_acc + prod_x4;
            end
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- rtl/core/four_voice_sample_playback_mixer.sv -----
// Wavetable sample player with VOICES voices mixed to one signed 16-bit PCM sample.
// Each input transfer carries an action: write one byte into sample memory, load one
// voice, set every voice volume, or render one output sample (the only action that
// yields a result transfer). Voices are served one after another by a small sequencer
// around one shared restoring divider and one multiply-accumulate. A render checks each
// voice in turn; a playing voice also has its byte address formed, its byte read and
// accumulated, with an extra wrap step when it is past its loop end, and the pass ends
// with a flush, the scale and the hand-over to the output register. The shared divider
// is used whenever it is needed: a voice at least one loop length past its loop end,
// a memory address beyond the memory depth when that depth is not a power of two, and
// the final divide by VOICES when VOICES is not a power of two. A finished sample
// waits in the output register while later writes and loads are still taken. Sample
// memory is not cleared by reset; reading a byte that was never written gives an
// arbitrary value.
// depends on fvspm_pkg, fvspm_chan_if, fvspm_div and fvspm_mac
module four_voice_sample_playback_mixer
    import fvspm_pkg::*;
#(
    parameter int VOICES              = VOICES_DEF,
    parameter int SAMPLE_MEMORY_DEPTH = MEM_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fvspm_chan_if.sink   i_item,
    fvspm_chan_if.source o_result
);

    // widths derived from the parameters
    localparam int VI_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ADDR_W   = $clog2(SAMPLE_MEMORY_DEPTH);
    localparam bit MEM_POW2 = (SAMPLE_MEMORY_DEPTH == (1 << ADDR_W));
    localparam int SUM_W    = LEN_W + 2;     // base plus in-range position
    localparam int AX_W     = (ADDR_W + 1 > SUM_W) ? ADDR_W + 1 : SUM_W;
    localparam int DIV_W0   = (ADDR_W + 1 > LEN_W) ? ADDR_W + 1 : LEN_W;
    localparam int VDIV_W   = $clog2(VOICES + 1);
    localparam int DIV_W    = (VDIV_W > DIV_W0) ? VDIV_W : DIV_W0;
    localparam int VSHIFT   = $clog2(VOICES);
    localparam bit V_POW2   = (VOICES == (1 << VSHIFT));
    localparam int ACC_W    = LEN_W + VSHIFT;
    localparam int INT_W    = POS_W - FRAC_W;

    localparam logic [AX_W-1:0]         DEPTH_X = AX_W'(SAMPLE_MEMORY_DEPTH);
    localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(PCM_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO  = ACC_W'(PCM_MIN);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WADDR,    // waiting for write address reduction
        S_CHECK,    // look at one voice
        S_WRAP,     // voice past its loop end
        S_LOOPDIV,  // waiting for loop remainder
        S_ADDR,     // form the byte address and read
        S_ADIV,     // waiting for read address reduction
        S_MAC,      // read data back, scale and accumulate
        S_FLUSH,    // last product reaches the accumulator
        S_SCALE,    // divide the sum by the voice count
        S_DDIV,     // waiting for the voice-count divide
        S_DONE      // saturate and hand over to the output register
    } t_state;

    // voice state
    logic [LEN_W-1:0]  r_base [VOICES];
    logic [LEN_W-1:0]  r_len  [VOICES];
    logic [LEN_W-1:0]  r_lb   [VOICES];
    logic [LEN_W-1:0]  r_ll   [VOICES];
    logic [STEP_W-1:0] r_step [VOICES];
    logic [POS_W-1:0]  r_pos  [VOICES];
    logic [VOL_W-1:0]  r_vol  [VOICES];

    // sample memory
    logic [SAMPLE_W-1:0] r_mem [SAMPLE_MEMORY_DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    // sequencer registers and their next values
    t_state             r_state,     n_state;
    logic [VI_W-1:0]    r_v,         n_v;
    logic [INT_W-1:0]   r_p,         n_p;
    logic [FRAC_W-1:0]  r_frac,      n_frac;
    logic [INT_W-1:0]   r_x,         n_x;
    logic [SAMPLE_W-1:0] r_wdata,    n_wdata;
    logic               r_neg,       n_neg;
    logic [ACC_W-1:0]   r_quo,       n_quo;
    logic               r_out_valid, n_out_valid;
    t_result            r_out_data,  n_out_data;

    // strobes from the sequencer
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                load_en;
    logic                vol_all_en;
    logic                step_clr;
    logic                mac_clr;
    logic                mac_add;

    // shared divider hookup
    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DIV_W-1:0] div_dsr;
    logic             div_busy;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic [DIV_W-1:0] div_rem;

    // current voice view and helpers
    logic [LEN_W-1:0]       cur_base, cur_len, cur_lb, cur_ll;
    logic [STEP_W-1:0]      cur_step;
    logic [POS_W-1:0]       cur_pos;
    logic [VOL_W-1:0]       cur_vol;
    logic [INT_W-1:0]       pos_int;
    logic [LEN_W:0]         loop_end;
    logic [AX_W-1:0]        ax;
    logic [AX_W-1:0]        wx;
    logic signed [ACC_W-1:0] mac_acc;
    logic [ACC_W-1:0]       acc_mag;
    logic signed [ACC_W-1:0] sres;
    logic signed [PCM_W-1:0] pcm_sat;
    logic [PLAY_W-1:0]      playing;
    logic                   accept;
    logic                   last_voice;
    logic                   load_ok;

    assign cur_base = r_base[r_v];
    assign cur_len  = r_len[r_v];
    assign cur_lb   = r_lb[r_v];
    assign cur_ll   = r_ll[r_v];
    assign cur_step = r_step[r_v];
    assign cur_pos  = r_pos[r_v];
    assign cur_vol  = r_vol[r_v];

    assign pos_int  = cur_pos[POS_W-1:FRAC_W];
    assign loop_end = {1'b0, cur_lb} + {1'b0, cur_ll};
    // position is below 2^18 here, so base plus position fits SUM_W bits
    assign ax       = AX_W'({2'b0, cur_base} + {1'b0, r_p[LEN_W:0]});
    assign wx       = AX_W'(i_item.data.address);

    assign acc_mag  = mac_acc[ACC_W-1] ? ACC_W'(-mac_acc) : ACC_W'(mac_acc);
    assign sres     = r_neg ? -$signed(r_quo) : $signed(r_quo);
    assign pcm_sat  = (sres > SAT_HI) ? PCM_W'(SAT_HI) :
                      (sres < SAT_LO) ? PCM_W'(SAT_LO) : sres[PCM_W-1:0];

    assign accept     = i_item.valid && (r_state == S_IDLE);
    assign last_voice = (r_v == VI_W'(VOICES - 1));
    assign load_ok    = (int'(i_item.data.voice) < VOICES);

    // playing flags for the first four voices only
    for (genvar gi = 0; gi < PLAY_W; gi++) begin : g_play
        if (gi < VOICES) begin : g_on
            assign playing[gi] = (r_step[gi] != '0);
        end else begin : g_off
            assign playing[gi] = 1'b0;
        end
    end

    // sequencer next-state logic
    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_p         = r_p;
        n_frac      = r_frac;
        n_x         = r_x;
        n_wdata     = r_wdata;
        n_neg       = r_neg;
        n_quo       = r_quo;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_data  = r_out_data;

        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = r_wdata;
        rd_en      = 1'b0;
        rd_addr    = '0;
        load_en    = 1'b0;
        vol_all_en = 1'b0;
        step_clr   = 1'b0;
        mac_clr    = 1'b0;
        mac_add    = 1'b0;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dsr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_item.data.action)
                        ACT_WRITE: begin
                            n_wdata = i_item.data.sample_byte;
                            if (MEM_POW2 || wx < DEPTH_X) begin
                                wr_en   = 1'b1;
                                wr_addr = wx[ADDR_W-1:0];
                                wr_data = i_item.data.sample_byte;
                            end else begin
                                div_start = 1'b1;
                                div_dvd   = DVD_W'(wx);
                                div_dsr   = DIV_W'(SAMPLE_MEMORY_DEPTH);
                                n_state   = S_WADDR;
                            end
                        end
                        ACT_LOAD: begin
                            load_en = load_ok;
                        end
                        ACT_VOLUME: begin
                            vol_all_en = 1'b1;
                        end
                        ACT_RENDER: begin
                            n_v     = '0;
                            mac_clr = 1'b1;
                            n_state = S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            S_WADDR: begin
                if (div_done) begin
                    wr_en   = 1'b1;
                    wr_addr = div_rem[ADDR_W-1:0];
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                n_p    = pos_int;
                n_frac = cur_pos[FRAC_W-1:0];
                if (cur_step == '0 || cur_len == '0) begin
                    // silent voice, nothing changes
                    n_v     = last_voice ? r_v : VI_W'(r_v + 1'b1);
                    n_state = last_voice ? S_FLUSH : S_CHECK;
                end else if (cur_ll != '0) begin
                    if (pos_int >= INT_W'(loop_end)) begin
                        n_x     = pos_int - INT_W'(loop_end);
                        n_state = S_WRAP;
                    end else begin
                        n_state = S_ADDR;
                    end
                end else if (pos_int >= INT_W'(cur_len)) begin
                    // one-shot voice ran off its end
                    step_clr = 1'b1;
                    n_v      = last_voice ? r_v : VI_W'(r_v + 1'b1);
                    n_state  = last_voice ? S_FLUSH : S_CHECK;
                end else begin
                    n_state = S_ADDR;
                end
            end
            S_WRAP: begin
                if (r_x < INT_W'(cur_ll)) begin
                    n_p     = INT_W'({1'b0, cur_lb} + {1'b0, r_x[LEN_W-1:0]});
                    n_state = S_ADDR;
                end else begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'(r_x);
                    div_dsr   = DIV_W'(cur_ll);
                    n_state   = S_LOOPDIV;
                end
            end
            S_LOOPDIV: begin
                if (div_done) begin
                    n_p     = INT_W'({1'b0, cur_lb} + {1'b0, div_rem[LEN_W-1:0]});
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                if (MEM_POW2 || ax < DEPTH_X) begin
                    rd_en   = 1'b1;
                    rd_addr = ax[ADDR_W-1:0];
                    n_state = S_MAC;
                end else begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'(ax);
                    div_dsr   = DIV_W'(SAMPLE_MEMORY_DEPTH);
                    n_state   = S_ADIV;
                end
            end
            S_ADIV: begin
                if (div_done) begin
                    rd_en   = 1'b1;
                    rd_addr = div_rem[ADDR_W-1:0];
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                mac_add = 1'b1;
                n_v     = last_voice ? r_v : VI_W'(r_v + 1'b1);
                n_state = last_voice ? S_FLUSH : S_CHECK;
            end
            S_FLUSH: begin
                n_state = S_SCALE;
            end
            S_SCALE: begin
                // divide the magnitude, so the quotient truncates toward zero
                n_neg = mac_acc[ACC_W-1];
                if (V_POW2) begin
                    n_quo   = acc_mag >> VSHIFT;
                    n_state = S_DONE;
                end else begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'(acc_mag);
                    div_dsr   = DIV_W'(VOICES);
                    n_state   = S_DDIV;
                end
            end
            S_DDIV: begin
                if (div_done) begin
                    n_quo   = div_quo[ACC_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to be free
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid               = 1'b1;
                    n_out_data.pcm_sample     = pcm_sat;
                    n_out_data.voices_playing = playing;
                    n_state                   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_v         <= n_v;
            r_out_valid <= n_out_valid;
        end
        r_p        <= n_p;
        r_frac     <= n_frac;
        r_x        <= n_x;
        r_wdata    <= n_wdata;
        r_neg      <= n_neg;
        r_quo      <= n_quo;
        r_out_data <= n_out_data;
    end

    // voice registers: load, set-all volume, and updates from the render pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICES; i++) begin
                r_base[i] <= '0;
                r_len[i]  <= '0;
                r_lb[i]   <= '0;
                r_ll[i]   <= '0;
                r_step[i] <= '0;
                r_pos[i]  <= '0;
                r_vol[i]  <= '0;
            end
        end else begin
            if (load_en) begin
                r_base[VI_W'(i_item.data.voice)] <= i_item.data.address;
                r_len[VI_W'(i_item.data.voice)]  <= i_item.data.sample_length;
                r_lb[VI_W'(i_item.data.voice)]   <= i_item.data.loop_begin;
                r_ll[VI_W'(i_item.data.voice)]   <= i_item.data.loop_length;
                r_step[VI_W'(i_item.data.voice)] <= i_item.data.step;
                r_vol[VI_W'(i_item.data.voice)]  <= clamp_volume(i_item.data.volume);
                r_pos[VI_W'(i_item.data.voice)]  <=
                    POS_W'({i_item.data.start_position, {FRAC_W{1'b0}}});
            end
            if (vol_all_en) begin
                for (int i = 0; i < VOICES; i++) begin
                    r_vol[i] <= clamp_volume(i_item.data.volume);
                end
            end
            if (step_clr) begin
                r_step[r_v] <= '0;
            end
            // position advances when the byte read is issued, wrap already applied
            if (rd_en) begin
                r_pos[r_v] <= {r_p, r_frac} + POS_W'(cur_step);
            end
        end
    end

    // sample memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    fvspm_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dvd),
        .i_divisor   (div_dsr),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    fvspm_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (mac_clr),
        .i_add   (mac_add),
        .i_byte  ($signed(r_rdata)),
        .i_vol   (cur_vol),
        .o_acc   (mac_acc)
    );

    // channel hookup
    assign i_item.ready   = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    // the shared divider is never restarted in the middle of a division
    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // every accumulate uses a byte fetched in the previous cycle
    a_mac_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_add |-> $past(rd_en))
        else $error("accumulate without a sample read");

    // reduced addresses always land inside the sample memory
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (AX_W'(rd_addr) < DEPTH_X))
        else $error("read address beyond sample memory");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (AX_W'(wr_addr) < DEPTH_X))
        else $error("write address beyond sample memory");

endmodule
